[hw/rtl/iirl_pkg.sv]
// shared types and codes for the indexed insert/remove list
// no dependencies; used by iirl_cell and indexed_insert_remove_list
package iirl_pkg;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OPCODE_W    = 3;
  localparam int unsigned POSITION_W  = 7;
  localparam int unsigned WORD_IN_W   = 32;
  localparam int unsigned WORD_OUT_W  = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_W     = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_GET     = 3'd3,
    OP_POP     = 3'd4,
    OP_REPLACE = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // what every cell does with the broadcast command
  typedef enum logic [2:0] {
    K_NONE,
    K_INSERT,
    K_REMOVE,
    K_READ,
    K_WRITE
  } cell_kind_t;

  typedef struct packed {
    logic       exec;
    cell_kind_t kind;
  } cell_cmd_t;

endpackage

[hw/rtl/indexed_insert_remove_list.sv]
// top level of the indexed insert/remove list: decode, cell row and result register
// depends on iirl_pkg and iirl_cell
//
// An ordered list of up to CAPACITY words held in a row of cells, one entry per
// cell. Every item is an operation (append, insert, remove, get, pop, replace)
// and yields exactly one result with the word read, a status and the new count.
// Insert and remove shift all affected entries at once, each cell taking its
// neighbor's word. One item is in work at a time: it is decoded on acceptance,
// the cell row updates and latches its read taps in the next cycle, and the
// taps are then OR-combined into the output register, which makes the result
// valid; only after that is the next item taken. While an earlier result still
// waits for out_tready the new result is held back, and the next item with it.
// A failed operation leaves the list unchanged.
// Entries carry no reset; only positions below the count are ever read.
module indexed_insert_remove_list
  import iirl_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // opcode [2:0], position [9:3], word_in [41:10], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // word_out [31:0], status [33:32], count [40:34], zero fill above
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned WW = (CW > POSITION_W) ? CW : POSITION_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  cell_kind_t        kind_r, kind_nxt;
  status_t           status_r, status_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     cmd_cnt_r;
  logic [WORD_WIDTH-1:0] word_r;
  logic              out_valid_r;
  logic [WORD_OUT_W-1:0] out_word_r;
  status_t           out_status_r;
  logic [COUNT_W-1:0] out_count_r;

  opcode_t           op_in;
  logic [WW-1:0]     pos_w, cnt_w;
  logic              full, accept;
  cell_cmd_t         cmd;
  logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
  logic [WORD_WIDTH-1:0] cell_tap  [CAPACITY];
  logic [WORD_WIDTH-1:0] rd_word;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign op_in     = opcode_t'(in_tdata[2:0]);
  assign pos_w     = WW'(in_tdata[9:3]);
  assign cnt_w     = WW'(cnt_r);
  assign full      = (cnt_r == FULL_CNT);

  // status, cell command and new count from the item and the current count
  always_comb begin
    kind_nxt   = K_NONE;
    status_nxt = ST_BAD_INDEX;
    pos_nxt    = pos_w[CW-1:0];
    cnt_nxt    = cnt_r;
    case (op_in)
      OP_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          kind_nxt   = K_INSERT;
          status_nxt = ST_OK;
          pos_nxt    = cnt_r;
          cnt_nxt    = cnt_r + 1'b1;
        end
      end
      OP_INSERT: begin
        if (pos_w > cnt_w) begin
          status_nxt = ST_BAD_INDEX;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          kind_nxt   = K_INSERT;
          status_nxt = ST_OK;
          cnt_nxt    = cnt_r + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos_w < cnt_w) begin
          kind_nxt   = K_REMOVE;
          status_nxt = ST_OK;
          cnt_nxt    = cnt_r - 1'b1;
        end
      end
      OP_GET: begin
        if (pos_w < cnt_w) begin
          kind_nxt   = K_READ;
          status_nxt = ST_OK;
        end
      end
      OP_POP: begin
        if (cnt_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          kind_nxt   = K_REMOVE;
          status_nxt = ST_OK;
          pos_nxt    = cnt_r - 1'b1;
          cnt_nxt    = cnt_r - 1'b1;
        end
      end
      OP_REPLACE: begin
        if (pos_w < cnt_w) begin
          kind_nxt   = K_WRITE;
          status_nxt = ST_OK;
        end
      end
      default: kind_nxt = K_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      kind_r      <= K_NONE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
            kind_r  <= kind_nxt;
            cnt_r   <= cnt_nxt;
          end
        end
        S_EXEC: begin
          state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!out_valid_r || out_tready) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_valid_r && out_tready && state_r != S_DRAIN) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      pos_r     <= pos_nxt;
      cmd_cnt_r <= cnt_r;
      word_r    <= WORD_WIDTH'(64'(in_tdata[41:10]));
    end
    if (state_r == S_DRAIN && (!out_valid_r || out_tready)) begin
      out_word_r   <= WORD_OUT_W'(64'(rd_word));
      out_status_r <= status_r;
      out_count_r  <= COUNT_W'(WW'(cnt_r));
    end
  end

  assign cmd.exec = (state_r == S_EXEC);
  assign cmd.kind = kind_r;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end
    iirl_cell #(
      .IDX    (g),
      .CW     (CW),
      .WORD_W (WORD_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos_r),
      .cnt        (cmd_cnt_r),
      .word_new   (word_r),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[g]),
      .tap        (cell_tap[g])
    );
  end

  // at most one tap is nonzero
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_tap[i];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_count_r, out_status_r, out_word_r};

endmodule

[hw/rtl/iirl_cell.sv]
// one list cell: holds a single entry, shifts with its neighbors, offers a read tap
// depends on iirl_pkg
module iirl_cell
  import iirl_pkg::*;
#(
  parameter int unsigned IDX    = 0,
  parameter int unsigned CW     = 7,
  parameter int unsigned WORD_W = 32
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [CW-1:0]     pos,
  input  logic [CW-1:0]     cnt,
  input  logic [WORD_W-1:0] word_new,
  input  logic [WORD_W-1:0] left_word,
  input  logic [WORD_W-1:0] right_word,
  output logic [WORD_W-1:0] word,
  output logic [WORD_W-1:0] tap
);

  localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
  localparam logic [CW-1:0] NXT_IDX = CW'(IDX + 1);

  logic [WORD_W-1:0] word_r, word_nxt;
  logic [WORD_W-1:0] tap_r;
  logic              hit;

  assign hit = (MY_IDX == pos);

  always_comb begin
    word_nxt = word_r;
    case (cmd.kind)
      K_INSERT: begin
        if (hit) begin
          word_nxt = word_new;
        end else if (MY_IDX > pos && MY_IDX <= cnt) begin
          word_nxt = left_word;
        end
      end
      K_REMOVE: begin
        if (MY_IDX >= pos && NXT_IDX < cnt) begin
          word_nxt = right_word;
        end
      end
      K_WRITE: begin
        if (hit) begin
          word_nxt = word_new;
        end
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      word_r <= word_nxt;
      // old contents go to the tap before the shift lands
      tap_r  <= (hit && (cmd.kind == K_REMOVE || cmd.kind == K_READ)) ? word_r : '0;
    end
  end

  assign word = word_r;
  assign tap  = tap_r;

endmodule
